[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the port-level checker of the path smoother.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication that also holds during reset.
`define CRS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, switched off while the reset is high.
`define CRS_ASSERT_NEXT_DIS(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/crs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Types, constants and the basis weight table of the Catmull-Rom smoother.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int SEGMENT_STEPS = 10;

  localparam int COORD_W  = 24;
  localparam int WEIGHT_W = 18;
  localparam int PROD_W   = COORD_W + WEIGHT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_W   = 16;

  // Sample index into the weight table, and the per-job item counter.
  localparam int JW    = (SEGMENT_STEPS > 1) ? $clog2(SEGMENT_STEPS) : 1;
  localparam int CNT_W = ($clog2(SEGMENT_STEPS + 1) > 2) ? $clog2(SEGMENT_STEPS + 1) : 2;

  localparam int QUEUE_DEPTH = 2;

  localparam longint WEIGHT_DEN  = 2 * SEGMENT_STEPS * SEGMENT_STEPS * SEGMENT_STEPS;
  localparam longint WEIGHT_HALF = WEIGHT_DEN / 2;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [3:0]              weight_set_t;
  typedef weight_set_t [SEGMENT_STEPS-1:0] weight_table_t;

  localparam weight_t ONE_WEIGHT = weight_t'(longint'(1) << FRAC_W);

  // One unit of work for the back end: the four points and what to emit.
  typedef struct packed {
    coord_t [3:0] px;
    coord_t [3:0] py;
    logic         seg;
    logic         last;
    logic [1:0]   held;
  } crs_job_t;

  // Q1.16 weight, rounded to nearest with ties away from zero.
  function automatic longint round_q16(longint num);
    longint q;
    if (num >= 0) begin
      q = (num * 65536 + WEIGHT_HALF) / WEIGHT_DEN;
    end else begin
      q = -((-num * 65536 + WEIGHT_HALF) / WEIGHT_DEN);
    end
    return q;
  endfunction

  function automatic weight_table_t build_weight_table();
    weight_table_t tbl;
    longint n;
    longint j;
    int     jj;
    n = SEGMENT_STEPS;
    for (jj = 0; jj < SEGMENT_STEPS; jj++) begin
      j = jj;
      tbl[jj][0] = weight_t'(round_q16(-j * n * n + 2 * j * j * n - j * j * j));
      tbl[jj][1] = weight_t'(round_q16(2 * n * n * n - 5 * j * j * n + 3 * j * j * j));
      tbl[jj][2] = weight_t'(round_q16(j * n * n + 4 * j * j * n - 3 * j * j * j));
      tbl[jj][3] = weight_t'(round_q16(-j * j * n + j * j * j));
    end
    return tbl;
  endfunction

  localparam weight_table_t WEIGHT_TABLE = build_weight_table();

endpackage

[hdl/crs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_front
// Takes path points, keeps the window of three held points and queues a job
// whenever a point causes output.
// ----------------------------------------------------------------------------
module crs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  crs_pkg::coord_t   in_x,
  input  crs_pkg::coord_t   in_y,
  input  logic              in_last,
  input  logic              queue_full,
  output logic              push,
  output crs_pkg::crs_job_t job
);
  import crs_pkg::*;

  coord_t     win_x [3];
  coord_t     win_y [3];
  coord_t     win_x_next [3];
  coord_t     win_y_next [3];
  logic [1:0] held;
  logic [1:0] held_next;
  logic       accept;
  logic       full_window;

  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign full_window = (held == 2'd3);
  assign push        = accept && (full_window || in_last);

  always_comb begin
    job.px[0] = win_x[0];
    job.px[1] = win_x[1];
    job.px[2] = win_x[2];
    job.px[3] = in_x;
    job.py[0] = win_y[0];
    job.py[1] = win_y[1];
    job.py[2] = win_y[2];
    job.py[3] = in_y;
    job.seg   = full_window;
    job.last  = in_last;
    job.held  = held;
  end

  always_comb begin
    win_x_next = win_x;
    win_y_next = win_y;
    held_next  = held;
    if (accept) begin
      if (in_last) begin
        win_x_next = '{default: '0};
        win_y_next = '{default: '0};
        held_next  = 2'd0;
      end else if (full_window) begin
        win_x_next[0] = win_x[1];
        win_x_next[1] = win_x[2];
        win_x_next[2] = in_x;
        win_y_next[0] = win_y[1];
        win_y_next[1] = win_y[2];
        win_y_next[2] = in_y;
      end else begin
        win_x_next[held] = in_x;
        win_y_next[held] = in_y;
        held_next        = held + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x <= '{default: '0};
      win_y <= '{default: '0};
      held  <= 2'd0;
    end else begin
      win_x <= win_x_next;
      win_y <= win_y_next;
      held  <= held_next;
    end
  end

endmodule

[hdl/crs_job_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_job_queue
// Two-entry queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module crs_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crs_pkg::crs_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output crs_pkg::crs_job_t head_job
);
  import crs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  crs_job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_Q-1:0]     count;
  logic [CNT_Q-1:0]     count_next;

  assign full       = (count == CNT_Q'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_Q'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

[hdl/crs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_back
// Steps through the items of each job and evaluates them in a four-stage
// weight, multiply, sum and round pipeline. Echoed points use a one-hot
// weight of exactly one, so they pass through the same arithmetic unchanged.
// ----------------------------------------------------------------------------
module crs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  crs_pkg::crs_job_t job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output crs_pkg::coord_t   out_x,
  output crs_pkg::coord_t   out_y,
  output logic              out_last
);
  import crs_pkg::*;

  // Round to nearest, ties away from zero, then clamp to the Q15.8 range.
  function automatic coord_t round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]        rnd;
    logic signed [ACC_W-FRAC_W-1:0] q;
    coord_t                         res;
    rnd = acc + (acc[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
    q   = rnd[ACC_W-1:FRAC_W];
    if (q[ACC_W-FRAC_W-1:COORD_W-1] == '0 || q[ACC_W-FRAC_W-1:COORD_W-1] == '1) begin
      res = q[COORD_W-1:0];
    end else if (q[ACC_W-FRAC_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] last_idx;
  logic             en;
  logic             issue;
  logic             is_sample;
  logic [1:0]       pt_sel;
  weight_set_t      w_sel;

  logic                    v1, v2, v3, v4;
  weight_set_t             w1;
  coord_t [3:0]            px1, py1;
  logic                    last1, last2, last3;
  logic signed [PROD_W-1:0] prod_x [4];
  logic signed [PROD_W-1:0] prod_y [4];
  logic signed [ACC_W-1:0]  acc_x, acc_y;

  // The whole pipeline advances together whenever the output word can move.
  assign en      = !v4 || out_ready;
  assign issue   = job_valid && en;
  assign job_pop = issue && (cnt == last_idx);

  always_comb begin
    if (job.seg) begin
      last_idx = job.last ? CNT_W'(SEGMENT_STEPS) : CNT_W'(SEGMENT_STEPS - 1);
    end else begin
      last_idx = CNT_W'(job.held);
    end
  end

  always_comb begin
    is_sample = job.seg && (cnt < CNT_W'(SEGMENT_STEPS));
    pt_sel    = (job.seg || cnt >= CNT_W'(job.held)) ? 2'd3 : cnt[1:0];
    w_sel     = '0;
    if (is_sample) begin
      w_sel = WEIGHT_TABLE[cnt[JW-1:0]];
    end else begin
      w_sel[pt_sel] = ONE_WEIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
    end else begin
      if (issue) begin
        cnt <= job_pop ? '0 : cnt + CNT_W'(1);
      end
      if (en) begin
        v1 <= issue;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1    <= w_sel;
      px1   <= job.px;
      py1   <= job.py;
      last1 <= !is_sample && (pt_sel == 2'd3);

      for (int k = 0; k < 4; k++) begin
        prod_x[k] <= $signed(px1[k]) * $signed(w1[k]);
        prod_y[k] <= $signed(py1[k]) * $signed(w1[k]);
      end
      last2 <= last1;

      acc_x <= ACC_W'(prod_x[0]) + ACC_W'(prod_x[1]) + ACC_W'(prod_x[2]) + ACC_W'(prod_x[3]);
      acc_y <= ACC_W'(prod_y[0]) + ACC_W'(prod_y[1]) + ACC_W'(prod_y[2]) + ACC_W'(prod_y[3]);
      last3 <= last2;

      out_x    <= round_sat(acc_x);
      out_y    <= round_sat(acc_y);
      out_last <= last3;
    end
  end

  assign out_valid = v4;

endmodule

[hdl/catmull_rom_path_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_path_smoother
// Uniform Catmull-Rom path smoother on a pair of streams.
// ----------------------------------------------------------------------------
// Path points come in one per word, the final point of a path flagged by
// s_tlast. From the fourth point on, every point yields SEGMENT_STEPS (10)
// smoothed samples of the segment between the two middle held points, one
// word per cycle from the back end while the output is not stalled; the
// final point adds one more word, the point itself with m_tlast set. A path
// of fewer than four points is echoed as it came. A point that yields
// nothing only fills the window and queues no job. The back end's item
// counter sets the rate, issuing one sample per cycle while not stalled
// into a four-stage weight, multiply, sum and round pipeline; a two-job
// queue lets the front take new points while the back end is still busy.
// Coordinates are signed Q15.8, results rounded to nearest and saturated.
// ----------------------------------------------------------------------------
module catmull_rom_path_smoother (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_coord [23:0], y_coord [47:24]
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_x [23:0], out_y [47:24]
  output logic        m_tlast    // end_of_path
);
  import crs_pkg::*;

  logic     push;
  logic     queue_full;
  logic     head_valid;
  logic     job_pop;
  crs_job_t push_job;
  crs_job_t head_job;
  coord_t   res_x;
  coord_t   res_y;

  crs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_x       (s_tdata[23:0]),
    .in_y       (s_tdata[47:24]),
    .in_last    (s_tlast),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  crs_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  crs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_last  (m_tlast)
  );

  assign m_tdata = {res_y, res_x};

endmodule

[hdl/crs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks on the path smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // Reset empties the output pipeline.
  `CRS_ASSERT_NEXT(a_reset_no_output, clk, rst, !m_tvalid, "output word valid after reset")

  // Reset empties the job queue, so the input side is open straight away.
  `CRS_ASSERT_NEXT(a_reset_ready, clk, rst, s_tready, "input not ready after reset")

  // A stalled output word keeps its contents.
  `CRS_ASSERT_NEXT_DIS(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")

endmodule

bind catmull_rom_path_smoother crs_checker u_checker (.*);

[verif/crs_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_sample_checker
// Watches both streams of the path smoother, predicts every output word from
// the accepted path points and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module crs_sample_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // x_coord [23:0], y_coord [47:24]
  input  logic        s_tlast,   // last_point
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // out_x [23:0], out_y [47:24]
  input  logic        m_tlast,   // end_of_path
  output int          mismatches,
  output int          outstanding
);

  import crs_pkg::coord_t;
  import crs_pkg::SEGMENT_STEPS;

  localparam int    REPORT_LIMIT = 10;
  localparam longint Q16_ONE     = 65536;
  localparam longint COORD_TOP   = 8388607;
  localparam longint COORD_BOTTOM = -8388608;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   eop;
  } path_sample_t;

  path_sample_t expected_samples[$];

  coord_t held_x[3];
  coord_t held_y[3];
  int     held_count;
  int     mismatch_total;

  initial begin
    held_count     = 0;
    mismatch_total = 0;
  end

  // Nearest integer of num / den for positive den, halves away from zero.
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // Basis weight k of sample j as a Q1.16 value.
  function automatic longint basis_q16(int j, int k);
    longint n;
    longint t;
    longint num;
    n = SEGMENT_STEPS;
    t = j;
    case (k)
      0:       num = -t * n * n + 2 * t * t * n - t * t * t;
      1:       num = 2 * n * n * n - 5 * t * t * n + 3 * t * t * t;
      2:       num = t * n * n + 4 * t * t * n - 3 * t * t * t;
      default: num = -t * t * n + t * t * t;
    endcase
    return div_nearest(num * Q16_ONE, 2 * n * n * n);
  endfunction

  function automatic coord_t spline_sample(coord_t p0, coord_t p1, coord_t p2,
                                           coord_t p3, int j);
    longint acc;
    longint v;
    acc = basis_q16(j, 0) * longint'(p0) + basis_q16(j, 1) * longint'(p1)
        + basis_q16(j, 2) * longint'(p2) + basis_q16(j, 3) * longint'(p3);
    v = div_nearest(acc, Q16_ONE);
    if (v > COORD_TOP) begin
      v = COORD_TOP;
    end
    if (v < COORD_BOTTOM) begin
      v = COORD_BOTTOM;
    end
    return coord_t'(v);
  endfunction

  task automatic push_expected(coord_t x, coord_t y, logic eop);
    path_sample_t s;
    s.px  = x;
    s.py  = y;
    s.eop = eop;
    expected_samples.insert(expected_samples.size(), s);
  endtask

  task automatic predict_point(coord_t x, coord_t y, logic last);
    int j;
    int i;
    if (held_count == 3) begin
      for (j = 0; j < SEGMENT_STEPS; j++) begin
        push_expected(spline_sample(held_x[0], held_x[1], held_x[2], x, j),
                      spline_sample(held_y[0], held_y[1], held_y[2], y, j), 1'b0);
      end
      if (!last) begin
        held_x[0] = held_x[1];
        held_y[0] = held_y[1];
        held_x[1] = held_x[2];
        held_y[1] = held_y[2];
        held_x[2] = x;
        held_y[2] = y;
      end
    end else if (!last) begin
      held_x[held_count] = x;
      held_y[held_count] = y;
      held_count++;
    end else begin
      // A short path is echoed as it came, oldest point first.
      for (i = 0; i < held_count; i++) begin
        push_expected(held_x[i], held_y[i], 1'b0);
      end
    end
    if (last) begin
      push_expected(x, y, 1'b1);
      held_count = 0;
      for (i = 0; i < 3; i++) begin
        held_x[i] = '0;
        held_y[i] = '0;
      end
    end
  endtask

  task automatic check_word(coord_t x, coord_t y, logic eop);
    path_sample_t want;
    if (expected_samples.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) begin
        $display("%0t: unexpected word x=%0d y=%0d last=%0b", $realtime, x, y, eop);
      end
    end else begin
      want = expected_samples.pop_front();
      if (want.px !== x || want.py !== y || want.eop !== eop) begin
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT) begin
          $display("%0t: word differs: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $realtime, want.px, want.py, want.eop, x, y, eop);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_word(coord_t'(m_tdata[23:0]), coord_t'(m_tdata[47:24]), m_tlast);
      end
      if (s_tvalid && s_tready) begin
        predict_point(coord_t'(s_tdata[23:0]), coord_t'(s_tdata[47:24]), s_tlast);
      end
    end
    mismatches  <= mismatch_total;
    outstanding <= expected_samples.size();
  end

endmodule

[verif/tb_catmull_rom_path_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catmull_rom_path_smoother
// Drives paths of random length and content into the smoother, with random
// gaps and back-pressure and one long output stall, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_catmull_rom_path_smoother;

  import crs_pkg::coord_t;

  localparam int RANDOM_ITEMS = 190;
  localparam int HOLD_AFTER   = 60;
  localparam int QUIET_AFTER  = 170;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 200000;

  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = -24'sh800000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // x_coord [23:0], y_coord [47:24]
  logic        s_tlast = 1'b0; // last_point
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // out_x [23:0], out_y [47:24]
  logic        m_tlast;        // end_of_path

  int mismatches;
  int outstanding;
  int points_sent = 0;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;
  bit hold_off_request = 1'b0;
  bit hold_off_done = 1'b0;

  always #2 clk = ~clk;

  catmull_rom_path_smoother dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  crs_sample_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 4))
      0:       return coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
      1:       return coord_t'($urandom_range(0, 2097151)) - coord_t'(1048576);
      2:       return $urandom_range(0, 1) ? C_MAX - coord_t'($urandom_range(0, 3))
                                           : C_MIN + coord_t'($urandom_range(0, 3));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Offers one point and returns at the edge where the word is taken.
  task automatic send_point(coord_t x, coord_t y, logic last);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    points_sent++;
    if (points_sent >= HOLD_AFTER) begin
      hold_off_request = 1'b1;
    end
    if (points_sent >= QUIET_AFTER) begin
      quiet_tail = 1'b1;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random back-pressure, one long stall so the input backs up,
  // and none at all in the tail of the run.
  initial begin
    int hold_cycles;
    forever begin
      if (hold_off_request && !hold_off_done) begin
        m_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_off_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    int path_len;
    int i;
    int random_sent;
    @(negedge rst);
    @(posedge clk);

    // Single-point path at the corners of the range.
    send_point(C_MAX, C_MIN, 1'b1);
    // Two- and three-point paths are echoed unchanged.
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b1);
    send_point(24'sd1, -24'sd1, 1'b0);
    send_point(-24'sd1, 24'sd1, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    // Overshoot between full-scale points drives the samples into saturation.
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);
    // Longer path, so the window shifts between segments.
    send_point(24'sd0, C_MAX, 1'b0);
    send_point(C_MAX, 24'sd0, 1'b0);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(24'sd256, -24'sd256, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(-24'sd1, 24'sd0, 1'b1);
    // Small, gently curving path.
    send_point(24'sd100, 24'sd10, 1'b0);
    send_point(24'sd200, 24'sd35, 1'b0);
    send_point(24'sd290, 24'sd80, 1'b0);
    send_point(24'sd370, 24'sd150, 1'b0);
    send_point(24'sd430, 24'sd240, 1'b1);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        path_len = $urandom_range(1, 3);
      end else begin
        path_len = $urandom_range(4, 12);
      end
      for (i = 0; i < path_len; i++) begin
        send_point(pick_coord(), pick_coord(), i == path_len - 1);
        random_sent++;
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
